### rtl/lfu_pr_pkg.sv
// Shared types and constants for the LFU page replacement block.
package lfu_pr_pkg;

  localparam int PAGE_W  = 8;
  localparam int PAGES   = 256;
  localparam int CNT_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TALLY_W = 32;
  localparam int CFG_W   = 4;
  localparam int SLOT_W  = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;

  typedef struct packed {
    logic start;
    logic look;
    logic scan;
    logic evict;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic place_found;
    logic scan_last;
  } sts_t;

endpackage

### rtl/lfu_page_replacement_top.sv
// Top level of the LFU page replacement block with oldest-reference tie-break.
//
// Usage: each item on the in_ channel is one page reference. The block keeps
// a saturating count per page and a last-reference time per resident frame,
// places the page in a hit frame or the first empty frame, and otherwise
// evicts the frame with the lowest count, the oldest reference breaking ties.
// Every item produces exactly one item on the out_ channel.
// Sequence: a hit or a placement into an empty frame goes from acceptance
// through the LOOK state to the DONE state, which loads the output register.
// A miss with all active frames full goes through LOOK, SCAN, EVICT and DONE;
// in SCAN the victim search walks the N active frames one per cycle, where N
// is the number of active frames. One item is in work at a time.
// cfg_we writes frames_in_use (0 acts as 1, values above FRAMES act as FRAMES);
// write it only while the block is idle.
// Reset (rst_n low, synchronous) empties all frames, clears all counts, the
// reference clock and the hit total, and sets frames_in_use to 8.
// A stalled receiver holds the result in the output register; the block still
// accepts and works on the next item, which then waits until the slot frees.
module lfu_page_replacement_top #(
  parameter int FRAMES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lfu_pr_pkg::PAGE_W-1:0]   in_page,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [lfu_pr_pkg::SLOT_W-1:0]   out_slot,
  output logic                            out_evicted_valid,
  output logic [lfu_pr_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [lfu_pr_pkg::TALLY_W-1:0]  out_hit_total,
  input  logic                            cfg_we,
  input  logic [lfu_pr_pkg::CFG_W-1:0]    cfg_wdata
);
  import lfu_pr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfu_pr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lfu_pr_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_page           (in_page),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total)
  );

endmodule

### rtl/lfu_pr_ctrl.sv
// Controller state machine that sequences lookup, victim scan, eviction and result hand-off.
module lfu_pr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lfu_pr_pkg::cmd_t   cmd,
  input  lfu_pr_pkg::sts_t   sts
);
  import lfu_pr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.start    = in_valid && in_ready;
  assign cmd.look     = (state_r == ST_LOOK);
  assign cmd.scan     = (state_r == ST_SCAN);
  assign cmd.evict    = (state_r == ST_EVICT);
  assign cmd.load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = sts.place_found ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.load_out) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/lfu_pr_dp.sv
// Datapath holding the frame table, the count memory, the clock, the victim scan and the outputs.
module lfu_pr_dp #(
  parameter int FRAMES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lfu_pr_pkg::cmd_t                cmd,
  output lfu_pr_pkg::sts_t                sts,
  input  logic [lfu_pr_pkg::PAGE_W-1:0]   in_page,
  input  logic                            cfg_we,
  input  logic [lfu_pr_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                            out_hit,
  output logic [lfu_pr_pkg::SLOT_W-1:0]   out_slot,
  output logic                            out_evicted_valid,
  output logic [lfu_pr_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [lfu_pr_pkg::TALLY_W-1:0]  out_hit_total
);
  import lfu_pr_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [CFG_W-1:0]   nframes_r;
  logic [FIDX_W-1:0]  lim;

  logic [FRAMES-1:0]  fr_vld_r;
  logic [PAGE_W-1:0]  fr_page_r [FRAMES];
  logic [CNT_W-1:0]   fr_cnt_r  [FRAMES];
  logic [TIME_W-1:0]  fr_time_r [FRAMES];

  logic [CNT_W-1:0]   cnt_mem [PAGES];
  logic [PAGES-1:0]   cnt_vld_r;
  logic [CNT_W-1:0]   rd_data_r;
  logic               rd_vld_r;
  logic               mem_we;
  logic [PAGE_W-1:0]  mem_addr;
  logic [CNT_W-1:0]   mem_wdata;

  logic [PAGE_W-1:0]  pg_r;
  logic [CNT_W-1:0]   cnt_cur, cnt_new, cnt_new_r;
  logic [TIME_W-1:0]  clock_r, stamp_r;

  logic               place_found;
  logic [FIDX_W-1:0]  place_idx;

  logic [FIDX_W-1:0]  scan_idx_r, best_idx_r;
  logic [CNT_W-1:0]   best_cnt_r, s_cnt;
  logic [TIME_W-1:0]  best_time_r, s_time;
  logic               scan_take;
  logic [PAGE_W-1:0]  ev_page;

  logic               hit_r, ev_r;
  logic [FIDX_W-1:0]  slot_r;
  logic [PAGE_W-1:0]  ev_page_r;

  logic               out_hit_r, out_ev_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [PAGE_W-1:0]  out_ev_page_r;
  logic [TALLY_W-1:0] tally_r;

  always_comb begin
    if (nframes_r == '0) begin
      lim = '0;
    end else if (32'(nframes_r) > FRAMES) begin
      lim = FIDX_W'(FRAMES - 1);
    end else begin
      lim = FIDX_W'(nframes_r - 1'b1);
    end
  end

  always_comb begin
    place_found = 1'b0;
    place_idx   = '0;
    for (int n = FRAMES - 1; n >= 0; n--) begin
      if ((FIDX_W'(n) <= lim) && (!fr_vld_r[n] || (fr_page_r[n] == pg_r))) begin
        place_found = 1'b1;
        place_idx   = FIDX_W'(n);
      end
    end
  end

  assign cnt_cur = rd_vld_r ? rd_data_r : '0;
  assign cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  assign s_cnt     = fr_cnt_r[scan_idx_r];
  assign s_time    = fr_time_r[scan_idx_r];
  assign scan_take = (scan_idx_r == '0) || (s_cnt < best_cnt_r) ||
                     ((s_cnt == best_cnt_r) && (s_time < best_time_r));
  assign ev_page   = fr_page_r[best_idx_r];

  assign sts.place_found = place_found;
  assign sts.scan_last   = (scan_idx_r == lim);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pg_r;
    mem_wdata = cnt_new;
    if (cmd.look) begin
      mem_we = 1'b1;
    end else if (cmd.evict) begin
      mem_we    = 1'b1;
      mem_addr  = ev_page;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[mem_addr] <= mem_wdata;
    if (cmd.start) begin
      rd_data_r <= cnt_mem[in_page];
      rd_vld_r  <= cnt_vld_r[in_page];
      pg_r      <= in_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      fr_vld_r  <= '0;
      nframes_r <= CFG_RESET;
      clock_r   <= '0;
      tally_r   <= '0;
    end else begin
      if (mem_we) cnt_vld_r[mem_addr] <= 1'b1;
      if (cmd.look && place_found) fr_vld_r[place_idx] <= 1'b1;
      if (cmd.evict) fr_vld_r[best_idx_r] <= 1'b1;
      if (cfg_we) nframes_r <= cfg_wdata;
      if (cmd.look) clock_r <= clock_r + 1'b1;
      if (cmd.load_out && hit_r && (tally_r != TALLY_MAX)) tally_r <= tally_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < FRAMES; n++) begin
      if (cmd.look) begin
        if (place_found && (FIDX_W'(n) == place_idx)) begin
          fr_page_r[n] <= pg_r;
          fr_cnt_r[n]  <= cnt_new;
          fr_time_r[n] <= clock_r;
        end else if (fr_vld_r[n] && (fr_page_r[n] == pg_r)) begin
          fr_cnt_r[n]  <= cnt_new;
          fr_time_r[n] <= clock_r;
        end
      end
      if (cmd.evict) begin
        if (FIDX_W'(n) == best_idx_r) begin
          fr_page_r[n] <= pg_r;
          fr_cnt_r[n]  <= cnt_new_r;
          fr_time_r[n] <= stamp_r;
        end else if (fr_vld_r[n] && (fr_page_r[n] == ev_page)) begin
          fr_cnt_r[n] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      cnt_new_r  <= cnt_new;
      stamp_r    <= clock_r;
      scan_idx_r <= '0;
      hit_r      <= place_found && fr_vld_r[place_idx];
      slot_r     <= place_idx;
      ev_r       <= 1'b0;
      ev_page_r  <= '0;
    end
    if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (scan_take) begin
        best_idx_r  <= scan_idx_r;
        best_cnt_r  <= s_cnt;
        best_time_r <= s_time;
      end
    end
    if (cmd.evict) begin
      hit_r     <= 1'b0;
      slot_r    <= best_idx_r;
      ev_r      <= 1'b1;
      ev_page_r <= ev_page;
    end
    if (cmd.load_out) begin
      out_hit_r     <= hit_r;
      out_slot_r    <= SLOT_W'(slot_r);
      out_ev_r      <= ev_r;
      out_ev_page_r <= ev_page_r;
    end
  end

  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_total     = tally_r;

endmodule

### rtl/lfu_pr_chk.sv
// Port-level checker for the LFU page replacement block and its bind to the top level.
module lfu_pr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [lfu_pr_pkg::SLOT_W-1:0]   out_slot,
  input logic                            out_evicted_valid,
  input logic [lfu_pr_pkg::PAGE_W-1:0]   out_evicted_page,
  input logic [lfu_pr_pkg::TALLY_W-1:0]  out_hit_total
);
  import lfu_pr_pkg::*;

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second item accepted while one is in work.");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid && (out_hit_total != '0))
    else $error("Hit result shows an eviction or a zero hit total.");

  a_no_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("Evicted page is nonzero without an eviction.");

  a_tally_steps: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (out_hit_total != $past(out_hit_total)) |->
      out_hit_total == $past(out_hit_total) + 1)
    else $error("Hit total changed by other than one.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_hit)
      && $stable(out_evicted_page) && $stable(out_hit_total))
    else $error("Stalled result changed.");

endmodule

bind lfu_page_replacement_top lfu_pr_chk u_lfu_pr_chk (.*);

### tb/testbench.sv
// Self-checking testbench for the LFU page replacement block, with its own replacement predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pr_pkg::*;

  localparam int FRAMES  = 8;
  localparam int LIMIT   = 4_000_000;
  localparam int HOLD_AT = 400;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [TALLY_W-1:0] hit_total;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PAGE_W-1:0]  in_page = '0;
  logic               out_valid;
  logic               out_ready;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [TALLY_W-1:0] out_hit_total;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  lfu_page_replacement_top #(.FRAMES(FRAMES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // Mirror of the block's replacement state.
  logic               frm_valid [FRAMES];
  logic [PAGE_W-1:0]  frm_page [FRAMES];
  logic [CNT_W-1:0]   ref_count [PAGES];
  logic [TIME_W-1:0]  ref_stamp [PAGES];
  logic [TIME_W-1:0]  stamp_clock;
  logic [TALLY_W-1:0] hit_sum;
  logic [CFG_W-1:0]   frames_cfg;

  logic [PAGE_W-1:0] page_stream [$];
  lookup_t           pending_lookups [$];

  int unsigned errors = 0;
  int unsigned accepted_n = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        idle_on = 1'b0;
  logic        stall_on = 1'b0;
  int unsigned idle_pct = 0;

  function automatic lookup_t predict_lookup(input logic [PAGE_W-1:0] pg);
    lookup_t           r;
    int unsigned       nf;
    logic [CNT_W-1:0]  low_cnt;
    logic [TIME_W-1:0] best_stamp;
    logic              placed;
    logic              have;
    r = '0;
    nf = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
    if (ref_count[pg] != CNT_MAX) ref_count[pg] = ref_count[pg] + 1'b1;
    ref_stamp[pg] = stamp_clock;
    stamp_clock = stamp_clock + 1'b1;
    placed = 1'b0;
    for (int n = 0; n < nf; n++) begin
      if (!placed && (!frm_valid[n] || frm_page[n] == pg)) begin
        r.hit = frm_valid[n];
        frm_valid[n] = 1'b1;
        frm_page[n] = pg;
        r.slot = SLOT_W'(n);
        placed = 1'b1;
      end
    end
    if (!placed) begin
      low_cnt = ref_count[frm_page[0]];
      for (int n = 1; n < nf; n++) begin
        if (ref_count[frm_page[n]] < low_cnt) low_cnt = ref_count[frm_page[n]];
      end
      have = 1'b0;
      best_stamp = '0;
      for (int n = 0; n < nf; n++) begin
        if (ref_count[frm_page[n]] == low_cnt &&
            (!have || ref_stamp[frm_page[n]] < best_stamp)) begin
          have = 1'b1;
          best_stamp = ref_stamp[frm_page[n]];
          r.slot = SLOT_W'(n);
        end
      end
      r.evicted_valid = 1'b1;
      r.evicted_page = frm_page[r.slot];
      ref_count[r.evicted_page] = '0;
      frm_page[r.slot] = pg;
    end
    if (r.hit && hit_sum != TALLY_MAX) hit_sum = hit_sum + 1'b1;
    r.hit_total = hit_sum;
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
        tx_gap <= $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (page_stream.size() != 0) begin
        in_valid <= 1'b1;
        in_page <= page_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
    end else if (stall_on && $urandom_range(0, 99) < 8) begin
      rx_gap <= $urandom_range(1, 13);
    end
  end

  // A long receiver hold-off lets the block fill up and push back on the sender.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_n == HOLD_AT) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  assign out_ready = (rx_gap == 0) && (hold_left == 0);

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_hit, out_slot, out_evicted_valid, out_evicted_page, out_hit_total};
        if (pending_lookups.size() == 0) begin
          if (errors < 10) $display("unexpected result item: hit=%0d slot=%0d", got.hit,
                                    got.slot);
          errors = errors + 1;
        end else begin
          want = pending_lookups.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("mismatch: expected hit=%0d slot=%0d ev=%0d evpage=%0d total=%0d",
                       want.hit, want.slot, want.evicted_valid, want.evicted_page,
                       want.hit_total);
              $display("          actual   hit=%0d slot=%0d ev=%0d evpage=%0d total=%0d",
                       got.hit, got.slot, got.evicted_valid, got.evicted_page,
                       got.hit_total);
            end
            errors = errors + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_lookups.push_back(predict_lookup(in_page));
        accepted_n <= accepted_n + 1;
      end
    end
  end

  task automatic await_idle();
    while (page_stream.size() != 0 || in_valid || pending_lookups.size() != 0)
      @(posedge clk);
    repeat (FRAMES + 4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    frames_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] ws_base;
    int unsigned       ws_size;
    logic [CFG_W-1:0]  value;
    logic [PAGE_W-1:0] seed_pages [12];
    for (int n = 0; n < FRAMES; n++) begin
      frm_valid[n] = 1'b0;
      frm_page[n] = '0;
    end
    for (int p = 0; p < PAGES; p++) begin
      ref_count[p] = '0;
      ref_stamp[p] = '0;
    end
    stamp_clock = '0;
    hit_sum = '0;
    frames_cfg = CFG_RESET;
    seed_pages = '{8'd0, 8'd255, 8'd0, 8'h55, 8'hAA, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5,
                   8'd255, 8'd0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill all frames, then force evictions decided by count and by age.
    foreach (seed_pages[i])
      page_stream.push_back(seed_pages[i]);
    await_idle();
    // A frame count of zero behaves as a single frame.
    write_frames(4'd0);
    page_stream.push_back(8'd7);
    page_stream.push_back(8'd8);
    page_stream.push_back(8'd7);
    await_idle();
    // Counts above the frame total behave as the full set.
    write_frames(4'd15);
    page_stream.push_back(8'd9);
    page_stream.push_back(8'd10);
    page_stream.push_back(8'd7);
    page_stream.push_back(8'h80);
    await_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: value = 4'd1;
        1: value = 4'd15;
        2: value = 4'd0;
        3: value = 4'd8;
        default: value = CFG_W'($urandom_range(0, 15));
      endcase
      write_frames(value);
      idle_on = (ph < 9) && ($urandom_range(0, 3) != 0);
      stall_on = (ph < 9) && ($urandom_range(0, 3) != 0);
      idle_pct = $urandom_range(0, 35);
      ws_base = PAGE_W'($urandom_range(0, 255));
      ws_size = $urandom_range(2, 12);
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 9) < 7)
          page_stream.push_back(PAGE_W'(ws_base + $urandom_range(0, ws_size - 1)));
        else
          page_stream.push_back(PAGE_W'($urandom_range(0, 255)));
      end
      await_idle();
    end

    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
